// ===== rtl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types, event codes and decode helpers for the parser modules.
// ----------------------------------------------------------------------------
package mbsp_pkg;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 4;
   localparam int CHAN_W   = 5;
   localparam int FIRST_W  = 9;
   localparam int SECOND_W = 14;
   localparam int OFFSET_W = 7;
   localparam int DATA_W   = 7;
   localparam int RSP_DATA_W = 40;

   localparam logic [KIND_W-1:0] EV_NONE        = 4'd0;
   localparam logic [KIND_W-1:0] EV_NOTE_ON     = 4'd1;
   localparam logic [KIND_W-1:0] EV_NOTE_OFF    = 4'd2;
   localparam logic [KIND_W-1:0] EV_CC          = 4'd3;
   localparam logic [KIND_W-1:0] EV_BEND        = 4'd4;
   localparam logic [KIND_W-1:0] EV_CHAN_PRESS  = 4'd5;
   localparam logic [KIND_W-1:0] EV_PROGRAM     = 4'd6;
   localparam logic [KIND_W-1:0] EV_POLY_PRESS  = 4'd7;
   localparam logic [KIND_W-1:0] EV_CLOCK       = 4'd8;
   localparam logic [KIND_W-1:0] EV_START       = 4'd9;
   localparam logic [KIND_W-1:0] EV_CONTINUE    = 4'd10;
   localparam logic [KIND_W-1:0] EV_STOP        = 4'd11;
   localparam logic [KIND_W-1:0] EV_SYSEX_START = 4'd12;
   localparam logic [KIND_W-1:0] EV_SYSEX_DATA  = 4'd13;
   localparam logic [KIND_W-1:0] EV_SYSEX_END   = 4'd14;

   // Running kind 8 marks an open SysEx.
   localparam logic [KIND_W-1:0] RUN_SYSEX_OPEN = 4'd8;

   localparam logic [BYTE_W-1:0] ST_SYSEX_START = 8'd240;
   localparam logic [BYTE_W-1:0] ST_SYSEX_END   = 8'd247;
   localparam logic [BYTE_W-1:0] ST_RT_CLOCK    = 8'd248;
   localparam logic [BYTE_W-1:0] ST_RT_START    = 8'd250;
   localparam logic [BYTE_W-1:0] ST_RT_CONTINUE = 8'd251;
   localparam logic [BYTE_W-1:0] ST_RT_STOP     = 8'd252;

   localparam logic [0:0] CSR_NOTE_OFFSET = 1'd0;
   localparam logic [0:0] CSR_THRU_ENABLE = 1'd1;

   localparam logic [OFFSET_W-1:0] NOTE_OFFSET_RESET = 7'h73; // -13

   typedef struct packed {
      logic [OFFSET_W-1:0] note_offset;
      logic                thru_enable;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   echo_byte;
      logic                echo_valid;
      logic                sysex_aborted;
      logic [SECOND_W-1:0] second_value;
      logic [FIRST_W-1:0]  first_value;
      logic [CHAN_W-1:0]   chan_num;
      logic [KIND_W-1:0]   event_kind;
   } result_type;

   // Channel message kind from the high nibble of a channel status byte.
   function automatic logic [KIND_W-1:0] kind_of_status(input logic [2:0] hi);
      logic [KIND_W-1:0] k;
      unique case (hi)
         3'd0:    k = EV_NOTE_OFF;
         3'd1:    k = EV_NOTE_ON;
         3'd2:    k = EV_POLY_PRESS;
         3'd3:    k = EV_CC;
         3'd4:    k = EV_PROGRAM;
         3'd5:    k = EV_CHAN_PRESS;
         3'd6:    k = EV_BEND;
         default: k = EV_NONE;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/mbsp_decode.sv =====
// ----------------------------------------------------------------------------
// MIDI byte decoder
// Holds running status, channel and pending first data byte, and decodes
// one received byte into one event result.
// ----------------------------------------------------------------------------
module mbsp_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [mbsp_pkg::BYTE_W-1:0] rx_byte,
   input  mbsp_pkg::cfg_type           cfg,
   output mbsp_pkg::result_type        result
);
   import mbsp_pkg::*;

   logic [KIND_W-1:0] run_kind_ff, run_kind_in;
   logic [CHAN_W-1:0] run_chan_ff, run_chan_in;
   logic [DATA_W-1:0] pend_data_ff, pend_data_in;
   logic              pend_valid_ff, pend_valid_in;

   logic [FIRST_W-1:0] note_sum;

   assign note_sum = {2'b00, pend_data_ff} + {{2{cfg.note_offset[OFFSET_W-1]}}, cfg.note_offset};

   always_comb begin
      run_kind_in   = run_kind_ff;
      run_chan_in   = run_chan_ff;
      pend_data_in  = pend_data_ff;
      pend_valid_in = pend_valid_ff;

      result               = '0;
      result.echo_valid    = cfg.thru_enable;
      result.echo_byte     = cfg.thru_enable ? rx_byte : '0;

      if (rx_byte[BYTE_W-1]) begin
         if (rx_byte >= ST_RT_CLOCK) begin
            // Realtime bytes pass through without touching any state.
            priority if (rx_byte == ST_RT_CLOCK)    result.event_kind = EV_CLOCK;
            else if (rx_byte == ST_RT_START)        result.event_kind = EV_START;
            else if (rx_byte == ST_RT_CONTINUE)     result.event_kind = EV_CONTINUE;
            else if (rx_byte == ST_RT_STOP)         result.event_kind = EV_STOP;
            else                                    result.event_kind = EV_NONE;
         end else if (run_kind_ff == RUN_SYSEX_OPEN && rx_byte == ST_SYSEX_END) begin
            result.event_kind  = EV_SYSEX_END;
            result.first_value = {1'b0, rx_byte};
            run_kind_in        = EV_NONE;
            pend_valid_in      = 1'b0;
         end else begin
            result.sysex_aborted = (run_kind_ff == RUN_SYSEX_OPEN);
            pend_valid_in        = 1'b0;
            if (rx_byte < ST_SYSEX_START) begin
               run_kind_in = kind_of_status(rx_byte[6:4]);
               run_chan_in = {1'b0, rx_byte[3:0]} + 5'd1;
            end else if (rx_byte == ST_SYSEX_START) begin
               run_kind_in        = RUN_SYSEX_OPEN;
               result.event_kind  = EV_SYSEX_START;
               result.first_value = {1'b0, rx_byte};
            end else begin
               run_kind_in = EV_NONE;
            end
         end
      end else begin
         if (run_kind_ff == RUN_SYSEX_OPEN) begin
            result.event_kind  = EV_SYSEX_DATA;
            result.first_value = {1'b0, rx_byte};
         end else if (run_kind_ff == EV_CHAN_PRESS || run_kind_ff == EV_PROGRAM) begin
            result.event_kind   = run_kind_ff;
            result.chan_num     = run_chan_ff;
            result.second_value = {7'd0, rx_byte[DATA_W-1:0]};
         end else if (run_kind_ff != EV_NONE && run_kind_ff <= EV_POLY_PRESS) begin
            if (!pend_valid_ff) begin
               pend_data_in  = rx_byte[DATA_W-1:0];
               pend_valid_in = 1'b1;
            end else begin
               pend_valid_in   = 1'b0;
               result.chan_num = run_chan_ff;
               if (run_kind_ff == EV_NOTE_ON || run_kind_ff == EV_NOTE_OFF) begin
                  // A note on with zero velocity is a note off.
                  result.event_kind   = (run_kind_ff == EV_NOTE_ON && rx_byte == '0)
                                        ? EV_NOTE_OFF : run_kind_ff;
                  result.first_value  = note_sum;
                  result.second_value = {7'd0, rx_byte[DATA_W-1:0]};
               end else if (run_kind_ff == EV_BEND) begin
                  // Subtracting the center flips the top bit of the 14-bit word.
                  result.event_kind   = EV_BEND;
                  result.second_value = {~rx_byte[DATA_W-1], rx_byte[DATA_W-2:0], pend_data_ff};
               end else begin
                  result.event_kind   = run_kind_ff;
                  result.first_value  = {2'b00, pend_data_ff};
                  result.second_value = {7'd0, rx_byte[DATA_W-1:0]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff   <= EV_NONE;
         run_chan_ff   <= '0;
         pend_data_ff  <= '0;
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         run_kind_ff   <= run_kind_in;
         run_chan_ff   <= run_chan_in;
         pend_data_ff  <= pend_data_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// ===== rtl/mbsp_out_skid.sv =====
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid entry so a new request is taken while a
// result waits on the response side.
// ----------------------------------------------------------------------------
module mbsp_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mbsp_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mbsp_pkg::result_type out_data
);
   import mbsp_pkg::*;

   result_type main_ff, skid_ff;
   logic       main_valid_ff, skid_valid_ff;
   logic       in_fire, out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_fire) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         if (!main_valid_ff) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (in_fire && !main_valid_ff) begin
         main_ff <= in_data;
      end
      if (in_fire && main_valid_ff && !out_fire) begin
         skid_ff <= in_data;
      end
   end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
// Latency: a result is registered in the output buffer before it appears on the response side.
// Throughput: one byte per cycle while the output buffer has room; the running-status decode is a single stage.
// A two-entry output buffer takes one more request while the response side stalls.
// Reset is synchronous and active high: running status, pending data and the
// output buffer are cleared, note_offset returns to -13 and thru to off.
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes a stream of MIDI bytes with running status into one event result per byte.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] chan_num, [13:5] first_value, [27:14] second_value,
   // [28] sysex_aborted, [29] echo_valid, [37:30] echo_byte, [39:38] zero
   output logic [mbsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mbsp_pkg::KIND_W-1:0]     rsp_tuser,  // [3:0] event_kind
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [mbsp_pkg::OFFSET_W-1:0]   csr_data
);
   import mbsp_pkg::*;

   cfg_type    cfg_ff;
   result_type dec_result, out_result;
   logic       req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.note_offset <= NOTE_OFFSET_RESET;
         cfg_ff.thru_enable <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NOTE_OFFSET: cfg_ff.note_offset <= csr_data;
            CSR_THRU_ENABLE: cfg_ff.thru_enable <= csr_data[0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   mbsp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .result  (dec_result)
   );

   mbsp_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (dec_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tuser = out_result.event_kind;
   assign rsp_tdata = {2'b00, out_result.echo_byte, out_result.echo_valid,
                       out_result.sysex_aborted, out_result.second_value,
                       out_result.first_value, out_result.chan_num};

endmodule

// ===== rtl/mbsp_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI parser port checker
// Watches the parser ports and flags results that break the event rules.
// ----------------------------------------------------------------------------
module mbsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mbsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mbsp_pkg::KIND_W-1:0]     rsp_tuser
);
   import mbsp_pkg::*;

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Only channel events carry a channel number, and they always do.
   a_chan_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser >= EV_NOTE_ON && rsp_tuser <= EV_POLY_PRESS)
                      == (rsp_tdata[4:0] != 5'd0)))
      else $error("channel number does not match event kind");

   // Echoed byte is zero whenever thru is off.
   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[29] |-> rsp_tdata[37:30] == 8'd0)
      else $error("echo byte set with thru off");

   // Nothing is presented right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
